// ===== rtl/idw_pkg.sv =====
// shared types and constants for the inverse distance weighting block
package idw_pkg;

    localparam int unsigned MaxSamplesDef = 16;
    localparam int unsigned MaxDimsDef    = 4;
    localparam int unsigned ResultCap     = 16;
    localparam int unsigned CfgDataW      = 5;
    localparam int unsigned CfgIdxW       = 1;

    localparam logic [CfgIdxW-1:0] RegNumSamples = 1'd0;
    localparam logic [CfgIdxW-1:0] RegNumDims    = 1'd1;

    localparam logic KindLoad  = 1'b0;
    localparam logic KindQuery = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [3:0]         sample_index;
        logic signed [31:0] coord0;
        logic signed [31:0] coord1;
        logic signed [31:0] coord2;
        logic signed [31:0] coord3;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  weight_index;
        logic [15:0] weight;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_DIFF,
        ST_ACC,
        ST_SQRT,
        ST_RECIP,
        ST_STORE,
        ST_WREAD,
        ST_WDIV,
        ST_EMIT
    } t_state;

    // request to the shared divider / root unit
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [65:0] num;
        logic [37:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [47:0] quo;
    } t_div_rsp;

endpackage

// ===== rtl/idw_div_unit.sv =====
// shared restoring divider and square root, one bit per cycle
module idw_div_unit
    import idw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    // divide: 48 quotient bits; root: 33 result bits of a 66 bit radicand
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_sqrt, n_sqrt;
    logic [5:0]  r_cnt, n_cnt;
    logic [65:0] r_num, n_num;
    logic [37:0] r_den, n_den;
    logic [67:0] r_rem, n_rem;
    logic [47:0] r_quo, n_quo;

    logic [67:0] w_trial_rem;
    logic [67:0] w_trial_sub;

    always_comb begin
        if (r_sqrt) begin
            w_trial_rem = {r_rem[65:0], r_num[65:64]};
            w_trial_sub = {32'd0, r_quo[33:0], 2'b01};
        end else begin
            w_trial_rem = {r_rem[66:0], r_num[65]};
            w_trial_sub = {30'd0, r_den};
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_sqrt = r_sqrt;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_sqrt = i_req.is_sqrt;
            n_num  = i_req.is_sqrt ? i_req.num : {i_req.num[47:0], 18'd0};
            n_den  = i_req.den;
            n_rem  = '0;
            n_quo  = '0;
            n_cnt  = i_req.is_sqrt ? 6'd33 : 6'd48;
        end else if (r_busy) begin
            n_num = r_sqrt ? {r_num[63:0], 2'b00} : {r_num[64:0], 1'b0};
            if (w_trial_rem >= w_trial_sub) begin
                n_rem = w_trial_rem - w_trial_sub;
                n_quo = {r_quo[46:0], 1'b1};
            end else begin
                n_rem = w_trial_rem;
                n_quo = {r_quo[46:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_sqrt <= n_sqrt;
        r_num  <= n_num;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("divider done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != 6'd0))
        else $error("divider busy with zero count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy)
        else $error("divider did not start");

endmodule

// ===== rtl/inverse_distance_weights.sv =====
// Shepard weights over a table of sample points; load items write a point, query items give one
// Q1.15 weight per sample in use. A load is taken from the idle state and then keeps busy high
// while its MAX_DIMS coordinates go into the table one per cycle. A query keeps busy high while
// the distance and reciprocal of each of the n samples in use (d dimensions) are formed and each
// weight is then normalized, all by the one shared bit-serial unit that does the 33-step root, the
// 48-step reciprocal and the 48-step normalizing division in turn; when every reciprocal is zero
// the division is skipped. Results appear one per o_valid strobe, the last one in the first
// cycle with busy low, and are taken as they come.
module inverse_distance_weights
    import idw_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
    parameter int unsigned MAX_DIMS    = MaxDimsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                start,
    output logic                busy,
    input  t_in_item            i_item,
    output logic                o_valid,
    output t_out_item           o_item
);

    localparam int unsigned SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int unsigned NCap = (MAX_SAMPLES < ResultCap) ? MAX_SAMPLES : ResultCap;
    localparam int unsigned PtsDepth = 1 << (SW + DW);

    t_state r_state, n_state;
    logic [4:0] r_num_samples;
    logic [2:0] r_num_dims;

    logic [31:0] mem_pts [PtsDepth];
    logic [31:0] mem_rcp [MAX_SAMPLES];
    logic [31:0] r_pt_rd;
    logic [31:0] r_rcp_rd;

    t_in_item    r_q;
    logic [SW:0] r_i;
    logic [DW:0] r_k;
    logic [SW:0] r_n;
    logic [DW:0] r_d;
    logic [31:0] r_mag;
    logic [65:0] r_acc;
    logic [37:0] r_sum;
    logic        r_valid;
    logic        r_div_go;
    t_out_item   r_out;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic signed [31:0] w_qc;
    logic signed [32:0] w_df;
    logic [63:0]        w_sq;
    logic [33:0]        w_dist;
    logic [32:0]        w_q;
    logic [31:0]        w_qsat;
    logic [47:0]        w_w;
    logic [SW+DW-1:0]   w_addr;
    logic [SW+DW-1:0]   w_load_addr;
    logic               w_load_ok;

    // clamp configuration
    logic [SW:0] w_n;
    logic [DW:0] w_d;
    always_comb begin
        if (r_num_samples == 5'd0) w_n = (SW+1)'(1);
        else if (32'(r_num_samples) > NCap) w_n = (SW+1)'(NCap);
        else w_n = (SW+1)'(r_num_samples);
        if (r_num_dims == 3'd0) w_d = (DW+1)'(1);
        else if (32'(r_num_dims) > MAX_DIMS) w_d = (DW+1)'(MAX_DIMS);
        else w_d = (DW+1)'(r_num_dims);
    end

    always_comb begin
        unique case (r_k[1:0])
            2'd0:    w_qc = r_q.coord0;
            2'd1:    w_qc = r_q.coord1;
            2'd2:    w_qc = r_q.coord2;
            default: w_qc = r_q.coord3;
        endcase
    end

    assign w_df   = 33'(w_qc) - 33'(signed'(r_pt_rd));
    assign w_sq   = 64'(r_mag) * 64'(r_mag);
    assign w_dist = w_rsp.quo[33:0] + 34'd1;
    assign w_q    = w_rsp.quo[32:0];
    assign w_qsat = w_q[32] ? 32'hFFFF_FFFF : w_q[31:0];
    assign w_w    = w_rsp.quo;
    assign w_addr = {r_i[SW-1:0], r_k[DW-1:0]};
    assign w_load_addr = {SW'(r_q.sample_index), r_k[DW-1:0]};
    assign w_load_ok = 32'(i_item.sample_index) < MAX_SAMPLES;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && i_item.kind == KindQuery) n_state = ST_READ;
                else if (start && w_load_ok) n_state = ST_LOAD;
            end
            ST_LOAD:  n_state = (r_k + 1'b1 == (DW+1)'(MAX_DIMS)) ? ST_IDLE : ST_LOAD;
            ST_READ:  n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_ACC;
            ST_ACC:   n_state = (r_k + 1'b1 == r_d) ? ST_SQRT : ST_READ;
            ST_SQRT:  if (w_rsp.done) n_state = ST_RECIP;
            ST_RECIP: if (w_rsp.done) n_state = ST_STORE;
            ST_STORE: n_state = (r_i + 1'b1 == r_n) ? ST_WREAD : ST_READ;
            ST_WREAD: n_state = ST_WDIV;
            ST_WDIV:  if (w_rsp.done || r_sum == '0) n_state = ST_EMIT;
            ST_EMIT:  n_state = (r_i + 1'b1 == r_n) ? ST_IDLE : ST_WREAD;
            default:  n_state = ST_IDLE;
        endcase
    end

    // divider requests
    always_comb begin
        w_req = '0;
        unique case (r_state)
            ST_ACC: begin
                w_req.start   = (r_k + 1'b1 == r_d);
                w_req.is_sqrt = 1'b1;
                w_req.num     = r_acc + 66'(w_sq);
            end
            ST_SQRT: begin
                w_req.start = w_rsp.done;
                w_req.num   = 66'(33'h1_0000_0000);
                w_req.den   = 38'(w_dist);
            end
            ST_WREAD: begin
                // a zero sum skips the division
            end
            ST_WDIV: ;
            default: ;
        endcase
        if (r_state == ST_WDIV && !w_rsp.busy && !w_rsp.done && r_sum != '0 && !r_valid
            && !r_div_go) begin
            w_req.start = 1'b1;
            w_req.num   = 66'({r_rcp_rd, 15'd0});
            w_req.den   = r_sum;
        end
    end

    logic [37:0] w_sum_n;
    assign w_sum_n = r_sum + 38'(w_qsat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_num_samples <= 5'd1;
            r_num_dims    <= 3'd2;
            r_valid       <= 1'b0;
            r_div_go      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_EMIT);
            if (i_cfg_we && i_cfg_idx == RegNumSamples) r_num_samples <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == RegNumDims)    r_num_dims <= i_cfg_data[2:0];
            r_div_go <= w_req.start ? 1'b1 : (r_state == ST_WREAD ? 1'b0 : r_div_go);
        end
        unique case (r_state)
            ST_IDLE: begin
                r_q   <= i_item;
                r_i   <= '0;
                r_k   <= '0;
                r_acc <= '0;
                r_sum <= '0;
                r_n   <= w_n;
                r_d   <= w_d;
            end
            ST_LOAD:  r_k <= r_k + 1'b1;
            ST_READ:  r_pt_rd <= mem_pts[w_addr];
            ST_DIFF:  r_mag <= w_df[32] ? 32'(-w_df) : 32'(w_df);
            ST_ACC: begin
                r_acc <= r_acc + 66'(w_sq);
                r_k   <= r_k + 1'b1;
            end
            ST_RECIP: if (w_rsp.done) r_sum <= w_sum_n;
            ST_STORE: begin
                r_i   <= (r_i + 1'b1 == r_n) ? '0 : r_i + 1'b1;
                r_k   <= '0;
                r_acc <= '0;
            end
            ST_WREAD: r_rcp_rd <= mem_rcp[r_i[SW-1:0]];
            ST_WDIV: begin
                if (w_rsp.done || r_sum == '0) begin
                    r_out.weight_index <= 4'(r_i);
                    r_out.weight <= (r_sum == '0) ? 16'd0 :
                        (w_w > 48'd32768 ? 16'd32768 : w_w[15:0]);
                    r_out.last <= (r_i + 1'b1 == r_n);
                end
            end
            ST_EMIT:  r_i <= r_i + 1'b1;
            default: ;
        endcase
        if (r_state == ST_RECIP && w_rsp.done) mem_rcp[r_i[SW-1:0]] <= w_qsat;
        if (r_state == ST_LOAD) mem_pts[w_load_addr] <= w_qc;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_item  = r_out;

    idw_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_IDLE || r_state == ST_WREAD))
        else $error("result outside emit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && start && i_item.kind == KindQuery) |=> busy)
        else $error("query transfer did not raise busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> w_rsp.busy || w_rsp.done)
        else $error("root not running");

endmodule
